/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the hash core.
// The macros assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/m64a_pkg.sv */
// Package for the MurmurHash64A core: constants, datapath commands, controller states.
// No dependencies; imported by m64a_dpath, m64a_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package m64a_pkg;

    localparam logic [63:0] M_CONST = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] M_LO    = M_CONST[31:0];
    localparam logic [31:0] M_HI    = M_CONST[63:32];
    localparam int          SHIFT_R = 47;
    localparam logic [3:0]  FULL_COUNT = 4'd8;

    typedef logic [63:0] word_t;
    typedef logic [3:0]  count_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_SET_H,
        DP_WORD,
        DP_FOLD_K,
        DP_MIX_K,
        DP_MIX_TAIL,
        DP_FOLD_H,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_full;
        logic cnt_zero;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BODY,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SET_H,
        S_FOLD_K,
        S_MIX_K,
        S_FIN_FOLD,
        S_EMIT
    } ctrl_state_t;

    // What the current 64-bit multiply is computing.
    typedef enum logic [2:0] {
        PH_INIT,
        PH_K1,
        PH_K2,
        PH_H,
        PH_FIN
    } mul_phase_t;

    function automatic word_t fold_high(input word_t v);
        fold_high = v ^ (v >> SHIFT_R);
    endfunction

    // Byte mask for a partial word of 0..7 valid bytes.
    function automatic word_t tail_mask(input count_t cnt);
        word_t m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (count_t'(i) < cnt) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        tail_mask = m;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/murmur64a_stream_hash_core.sv */
// Top level of the streaming MurmurHash64A (seed zero) core.
// Depends on m64a_pkg, m64a_ctrl and m64a_dpath.
//
// Usage:
//  - Input channel (item_valid / item_stall) carries one 8-byte little-endian word per
//    transfer with byte_count, first_word, last_word and message_length. message_length
//    is used only on a transfer with first_word set and seeds the hash.
//  - Output channel (hash_valid / hash_stall) carries one hash_value per message, after
//    the transfer that has last_word set. An empty message is one transfer with zero bytes.
//  - Every 64-bit multiply by the mixing constant takes three passes through one shared
//    32x32 multiplier, so how long an item holds the input is set by its multiplies:
//    none for a zero-byte word, one for a partial word, three for a full word;
//    one more when first_word is set, and one more (through the result register) when
//    last_word is set.
//  - One item is worked at a time; item_stall is high from the cycle after a transfer
//    until the item's work is done.
//  - The result sits in an output register, so a new message may start while the last
//    hash waits on hash_stall. A second result waits behind a stalled one; nothing is
//    dropped and hash_value holds while stalled.
//  - Reset (rst_n low, asynchronous) clears the running hash to zero, idles the
//    controller and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module murmur64a_stream_hash_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        first_word,
    input  wire logic        last_word,
    input  wire logic [63:0] message_length,
    output logic             hash_valid,
    input  wire logic        hash_stall,
    output logic [63:0]      hash_value
);
    import m64a_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: decides which datapath operation runs each cycle.
    m64a_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .first_word (first_word),
        .last_word  (last_word),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Hash state, work register, shared multiplier and result register.
    m64a_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .message_length (message_length),
        .hash_value     (hash_value)
    );

endmodule

`default_nettype wire

/* rtl/core/m64a_dpath.sv */
// Datapath of the MurmurHash64A core: running hash, work word, one shared 32x32 multiplier.
// Depends on m64a_pkg; driven by m64a_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module m64a_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire m64a_pkg::dp_cmd_t cmd,
    output m64a_pkg::dp_stat_t     stat,
    input  wire logic [63:0]       data_word,
    input  wire logic [3:0]        byte_count,
    input  wire logic [63:0]       message_length,
    output logic [63:0]            hash_value
);
    import m64a_pkg::*;

    word_t  h_reg;
    word_t  mop_reg,  mop_next;
    word_t  prod_reg, prod_next;
    word_t  word_reg;
    count_t cnt_reg;
    word_t  out_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] hi_sum;

    // Low 64 bits of mop * M as three 32x32 partial products.
    always_comb begin
        mul_a = mop_reg[31:0];
        mul_b = M_LO;
        case (cmd.op)
            DP_MUL1: mul_b = M_HI;
            DP_MUL2: mul_a = mop_reg[63:32];
            default: ;
        endcase
    end

    assign mul_p  = 64'(mul_a) * 64'(mul_b);
    assign hi_sum = prod_reg[63:32] + mul_p[31:0];

    always_comb begin
        mop_next  = mop_reg;
        prod_next = prod_reg;
        case (cmd.op)
            DP_LOAD:     mop_next  = message_length;
            DP_MUL0:     prod_next = mul_p;
            DP_MUL1:     prod_next = {hi_sum, prod_reg[31:0]};
            DP_MUL2:     mop_next  = {hi_sum, prod_reg[31:0]};
            DP_WORD:     mop_next  = word_reg;
            DP_FOLD_K:   mop_next  = fold_high(mop_reg);
            DP_MIX_K:    mop_next  = h_reg ^ mop_reg;
            DP_MIX_TAIL: mop_next  = h_reg ^ (word_reg & tail_mask(cnt_reg));
            DP_FOLD_H:   mop_next  = fold_high(h_reg);
            default: ;
        endcase
    end

    // Running hash is architectural state and resets to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
        end
        else if (cmd.op == DP_SET_H)
        begin
            h_reg <= mop_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mop_reg  <= mop_next;
        prod_reg <= prod_next;
        if (cmd.op == DP_LOAD)
        begin
            word_reg <= data_word;
            cnt_reg  <= (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
        end
        if (cmd.op == DP_EMIT)
        begin
            out_reg <= fold_high(mop_reg);
        end
    end

    assign stat.cnt_full = (cnt_reg == FULL_COUNT);
    assign stat.cnt_zero = (cnt_reg == '0);
    assign hash_value    = out_reg;

endmodule

`default_nettype wire

/* rtl/core/m64a_ctrl.sv */
// Controller of the MurmurHash64A core: sequences multiplies, mixing and result hand-off.
// Depends on m64a_pkg; commands m64a_dpath.
`timescale 1ns / 1ps
`default_nettype none

module m64a_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic               first_word,
    input  wire logic               last_word,
    output logic                    hash_valid,
    input  wire logic               hash_stall,
    output m64a_pkg::dp_cmd_t       cmd,
    input  wire m64a_pkg::dp_stat_t stat
);
    import m64a_pkg::*;

    ctrl_state_t state_reg, state_next;
    mul_phase_t  ph_reg,    ph_next;
    logic        last_reg,  last_next;
    logic        valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_INIT;
            last_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        last_next  = last_reg;
        valid_next = valid_reg && hash_stall;
        cmd.op     = DP_NOP;

        unique case (state_reg)
            S_IDLE: begin
                if (item_valid)
                begin
                    cmd.op     = DP_LOAD;
                    last_next  = last_word;
                    if (first_word)
                    begin
                        ph_next    = PH_INIT;
                        state_next = S_MUL0;
                    end
                    else
                    begin
                        state_next = S_BODY;
                    end
                end
            end
            S_BODY: begin
                if (stat.cnt_full)
                begin
                    cmd.op     = DP_WORD;
                    ph_next    = PH_K1;
                    state_next = S_MUL0;
                end
                else if (!stat.cnt_zero)
                begin
                    cmd.op     = DP_MIX_TAIL;
                    ph_next    = PH_H;
                    state_next = S_MUL0;
                end
                else
                begin
                    state_next = last_reg ? S_FIN_FOLD : S_IDLE;
                end
            end
            S_MUL0: begin
                cmd.op     = DP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                cmd.op     = DP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.op = DP_MUL2;
                unique case (ph_reg)
                    PH_K1:   state_next = S_FOLD_K;
                    PH_K2:   state_next = S_MIX_K;
                    PH_FIN:  state_next = S_EMIT;
                    default: state_next = S_SET_H;
                endcase
            end
            S_SET_H: begin
                cmd.op = DP_SET_H;
                if (ph_reg == PH_INIT)
                begin
                    state_next = S_BODY;
                end
                else
                begin
                    state_next = last_reg ? S_FIN_FOLD : S_IDLE;
                end
            end
            S_FOLD_K: begin
                cmd.op     = DP_FOLD_K;
                ph_next    = PH_K2;
                state_next = S_MUL0;
            end
            S_MIX_K: begin
                cmd.op     = DP_MIX_K;
                ph_next    = PH_H;
                state_next = S_MUL0;
            end
            S_FIN_FOLD: begin
                cmd.op     = DP_FOLD_H;
                ph_next    = PH_FIN;
                state_next = S_MUL0;
            end
            S_EMIT: begin
                // Hold until the output register is free or being drained.
                if (!(valid_reg && hash_stall))
                begin
                    cmd.op     = DP_EMIT;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign item_stall = (state_reg != S_IDLE);
    assign hash_valid = valid_reg;

endmodule

`default_nettype wire

/* rtl/core/m64a_checker.sv */
// Port-level checker for the MurmurHash64A core, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module m64a_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_stall,
    input wire logic        last_word,
    input wire logic        hash_valid,
    input wire logic        hash_stall,
    input wire logic [63:0] hash_value
);

    logic item_xfer;

    assign item_xfer = item_valid && !item_stall;

    // A stalled result stays offered.
    `ASSERT_NEXT(a_hold_valid, hash_valid && hash_stall, hash_valid, "result dropped while stalled")

    // A stalled result does not change.
    `ASSERT_NEXT(a_hold_value, hash_valid && hash_stall, $stable(hash_value), "result changed while stalled")

    // Each item keeps the block busy for at least the following cycle.
    `ASSERT_NEXT(a_busy_after_xfer, item_xfer, item_stall, "input taken back to back")

    // A new result only comes out of item work, never from an idle block.
    `ASSERT_NOW(a_result_from_work, $rose(hash_valid), $past(item_stall), "result without work")

    // A word that does not end its message gives no result straight after its transfer.
    `ASSERT_NEXT(a_no_early_result, item_xfer && !last_word, !$rose(hash_valid) ##1 !$rose(hash_valid), "result for a non-final word")

endmodule

bind murmur64a_stream_hash_core m64a_checker u_m64a_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .last_word  (last_word),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash_value (hash_value)
);

`default_nettype wire
